// ----- design/bba_pkg.sv -----
// shared request codes and controller/datapath interface types
package bba_pkg;

  localparam logic [1:0] REQ_EXTEND = 2'd0;
  localparam logic [1:0] REQ_INSIDE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam int SQ_AXES = 3;

  typedef struct packed {
    logic       load_req;
    logic       exec;
    logic       sq_mul;
    logic       sq_acc;
    logic [1:0] sq_axis;
    logic       root_step;
    logic       commit;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic grow;
  } sts_t;

endpackage

// ----- design/bba_ctrl.sv -----
// sequencing state machine for the box accumulator
module bba_ctrl #(
  parameter int COORD_WIDTH = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);
  import bba_pkg::*;

  localparam int CW = $clog2(COORD_WIDTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SQUARE = 6'b000100,
    S_ROOT   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_valid_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.sq_axis    = cnt[1:0];
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_next = '0;
        state_next = sts.grow ? S_SQUARE : S_FINISH;
      end
      S_SQUARE: begin
        cmd.sq_mul = (cnt < CW'(SQ_AXES));
        cmd.sq_acc = (cnt != '0);
        if (cnt == CW'(SQ_AXES)) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CW'(COORD_WIDTH)) begin
          state_next = S_UPDATE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.commit = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/bba_datapath.sv -----
// box state, center and radius arithmetic, result register
module bba_datapath #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                 sts,
  input  logic [1:0]                    req_type,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          hit_flag,
  output logic                          box_valid,
  output logic signed [COORD_WIDTH-1:0] low_x,
  output logic signed [COORD_WIDTH-1:0] low_y,
  output logic signed [COORD_WIDTH-1:0] low_z,
  output logic signed [COORD_WIDTH-1:0] high_x,
  output logic signed [COORD_WIDTH-1:0] high_y,
  output logic signed [COORD_WIDTH-1:0] high_z,
  output logic signed [COORD_WIDTH-1:0] mid_x,
  output logic signed [COORD_WIDTH-1:0] mid_y,
  output logic signed [COORD_WIDTH-1:0] mid_z,
  output logic [COORD_WIDTH-1:0]        half_diagonal
);
  import bba_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int AW = 2 * W + 2;
  localparam int RW = W + 2;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic [1:0]          req_q;
  logic signed [W-1:0] pt [3];
  logic signed [W-1:0] lo [3];
  logic signed [W-1:0] hi [3];
  logic signed [W-1:0] mid [3];
  logic [W-1:0]        rad;
  logic                box_ok;
  logic                hit;
  logic [2*W-1:0]      prod;
  logic [AW-1:0]       acc;
  logic [RW-1:0]       rem;
  logic [W:0]          root;

  logic [2:0]          below, above;
  logic                moved, in_box;
  logic signed [W:0]   diff [3];
  logic [W-1:0]        ud [3];
  logic signed [W:0]   mid_sum [3];
  logic [W-1:0]        sq_in;
  logic [2*W-1:0]      sq_wide;
  logic [RW+1:0]       trial, sub, tdiff;
  logic                take;
  logic [RW-1:0]       rem_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      below[i]   = pt[i] < lo[i];
      above[i]   = pt[i] > hi[i];
      diff[i]    = {hi[i][W-1], hi[i]} - {lo[i][W-1], lo[i]};
      ud[i]      = diff[i][W] ? '0 : diff[i][W-1:0];
      mid_sum[i] = {lo[i][W-1], lo[i]} + {hi[i][W-1], hi[i]};
    end
    moved    = |below || |above;
    in_box   = !(|below) && !(|above);
    sts.grow = (req_q == REQ_EXTEND) && moved;
    case (cmd.sq_axis)
      2'd0:    sq_in = ud[0];
      2'd1:    sq_in = ud[1];
      2'd2:    sq_in = ud[2];
      default: sq_in = '0;
    endcase
    sq_wide  = {{W{1'b0}}, sq_in};
    trial    = {rem, acc[AW-1 -: 2]};
    sub      = {1'b0, root, 2'b01};
    take     = trial >= sub;
    tdiff    = trial - sub;
    rem_next = take ? tdiff[RW-1:0] : trial[RW-1:0];
  end

  // box state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lo[i]  <= CMAX;
        hi[i]  <= CMIN;
        mid[i] <= '0;
      end
      rad    <= '0;
      box_ok <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (req_q)
          REQ_EXTEND: begin
            for (int i = 0; i < 3; i++) begin
              if (below[i]) lo[i] <= pt[i];
              if (above[i]) hi[i] <= pt[i];
            end
          end
          REQ_CLEAR: begin
            for (int i = 0; i < 3; i++) begin
              lo[i]  <= CMAX;
              hi[i]  <= CMIN;
              mid[i] <= '0;
            end
            rad    <= '0;
            box_ok <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        for (int i = 0; i < 3; i++) mid[i] <= mid_sum[i][W:1];
        rad    <= root[W:1];
        box_ok <= 1'b1;
      end
    end
  end

  // request beat, squares and bit-pair square root
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_type;
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
    end
    if (cmd.exec) begin
      hit <= (req_q == REQ_EXTEND) ? moved : ((req_q == REQ_INSIDE) ? in_box : 1'b0);
    end
    if (cmd.sq_mul) prod <= sq_wide * sq_wide;
    if (cmd.exec) begin
      acc  <= '0;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sq_acc) begin
      acc <= acc + {2'b00, prod};
    end else if (cmd.root_step) begin
      acc  <= {acc[AW-3:0], 2'b00};
      rem  <= rem_next;
      root <= {root[W-1:0], take};
    end
    if (cmd.out_load) begin
      hit_flag      <= hit;
      box_valid     <= box_ok;
      low_x         <= lo[0];
      low_y         <= lo[1];
      low_z         <= lo[2];
      high_x        <= hi[0];
      high_y        <= hi[1];
      high_z        <= hi[2];
      mid_x         <= mid[0];
      mid_y         <= mid[1];
      mid_z         <= mid[2];
      half_diagonal <= rad;
    end
  end

endmodule

// ----- design/bounding_box_accumulator.sv -----
// running axis-aligned bounding box: top level
// inside, invalidate and non-growing extend beats pass from the execute state straight to finish
// a growing extend first multiplies and accumulates the squared extents of the three axes,
// then takes one square root bit per cycle over COORD_WIDTH+1 steps
// one beat is in flight at a time; the next beat is taken while the result waits on out_ready
// synchronous reset empties the box and clears out_valid
module bounding_box_accumulator #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit_flag,
  output logic                          box_valid,
  output logic signed [COORD_WIDTH-1:0] low_x,
  output logic signed [COORD_WIDTH-1:0] low_y,
  output logic signed [COORD_WIDTH-1:0] low_z,
  output logic signed [COORD_WIDTH-1:0] high_x,
  output logic signed [COORD_WIDTH-1:0] high_y,
  output logic signed [COORD_WIDTH-1:0] high_z,
  output logic signed [COORD_WIDTH-1:0] mid_x,
  output logic signed [COORD_WIDTH-1:0] mid_y,
  output logic signed [COORD_WIDTH-1:0] mid_z,
  output logic [COORD_WIDTH-1:0]        half_diagonal
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .hit_flag      (hit_flag),
    .box_valid     (box_valid),
    .low_x         (low_x),
    .low_y         (low_y),
    .low_z         (low_z),
    .high_x        (high_x),
    .high_y        (high_y),
    .high_z        (high_z),
    .mid_x         (mid_x),
    .mid_y         (mid_y),
    .mid_z         (mid_z),
    .half_diagonal (half_diagonal)
  );

endmodule

// ----- design/bba_checker.sv -----
// port-level assertions for the box accumulator, bound to the top level
module bba_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    req_type,
  input logic signed [COORD_WIDTH-1:0] point_x,
  input logic signed [COORD_WIDTH-1:0] point_y,
  input logic signed [COORD_WIDTH-1:0] point_z,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit_flag,
  input logic                          box_valid,
  input logic signed [COORD_WIDTH-1:0] low_x,
  input logic signed [COORD_WIDTH-1:0] low_y,
  input logic signed [COORD_WIDTH-1:0] low_z,
  input logic signed [COORD_WIDTH-1:0] high_x,
  input logic signed [COORD_WIDTH-1:0] high_y,
  input logic signed [COORD_WIDTH-1:0] high_z,
  input logic signed [COORD_WIDTH-1:0] mid_x,
  input logic signed [COORD_WIDTH-1:0] mid_y,
  input logic signed [COORD_WIDTH-1:0] mid_z,
  input logic [COORD_WIDTH-1:0]        half_diagonal
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(half_diagonal) && $stable(low_x))
    else $error("result beat dropped or changed while stalled");

  // one beat in flight: no accept right after an accept
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in flight");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // an empty box reports zero center and radius
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !box_valid |->
      half_diagonal == '0 && mid_x == '0 && mid_y == '0 && mid_z == '0)
    else $error("empty box with nonzero center or radius");

  // a box that is valid has ordered corners
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && box_valid |-> low_x <= high_x && low_y <= high_y && low_z <= high_z)
    else $error("valid box with crossed corners");

endmodule

bind bounding_box_accumulator bba_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bba_checker (.*);
